@@ hdl/sbrh_pkg.sv @@
// Shared types, constants and controller codes for the rolling-hash border finder.
package sbrh_pkg;

    localparam int unsigned HASH_W       = 30;
    localparam int unsigned MAX_LEN_DEF  = 64;
    localparam int unsigned LEN_OUT_W    = 6;
    localparam logic [HASH_W-1:0] HASH_MOD   = 30'd1000000007;
    localparam logic [HASH_W-1:0] BASE_RESET = 30'd257;
    localparam logic [LEN_OUT_W-1:0] MAX_REPORTS = 6'd63;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } item_t;

    typedef struct packed {
        logic [LEN_OUT_W-1:0] border_length;
        logic                 end_of_list;
        logic                 truncated;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISP,
        ST_MPS,
        ST_MPW,
        ST_MHS,
        ST_MHW,
        ST_SINIT,
        ST_RDW,
        ST_LATW,
        ST_RDS,
        ST_MST,
        ST_MWT,
        ST_RDP,
        ST_CMP,
        ST_CHK,
        ST_END
    } state_t;

    typedef enum logic [1:0] {
        MUL_POW,
        MUL_HASH,
        MUL_SRCH
    } mul_sel_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_PREV,
        RD_WHOLE,
        RD_SUFFIX,
        RD_PREFIX
    } rd_op_t;

    typedef struct packed {
        logic     load_item;
        rd_op_t   rd_op;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     save_pow;
        logic     write_first;
        logic     write_next;
        logic     mark_ovf;
        logic     init_search;
        logic     latch_whole;
        logic     emit_cmp;
        logic     next_len;
        logic     emit_end;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic last;
        logic mul_done;
        logic search_over;
    } status_t;

endpackage

@@ hdl/sbrh_modmul.sv @@
// Iterative modular multiplier: one bit of the multiplier per cycle.
module sbrh_modmul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [sbrh_pkg::HASH_W-1:0] a,
    input  logic [sbrh_pkg::HASH_W-1:0] b,
    output logic                       done,
    output logic [sbrh_pkg::HASH_W-1:0] prod
);
    import sbrh_pkg::*;

    localparam int unsigned CNT_W = $clog2(HASH_W + 1);

    logic [HASH_W-1:0] a_reg, b_reg, r_reg;
    logic [HASH_W-1:0] a_next, b_next, r_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [HASH_W:0]   dbl, dbl_red, acc;
    logic [HASH_W-1:0] dbl_mod;

    // One step: double the partial result, then add a when the multiplier bit is set.
    always_comb
    begin
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, HASH_MOD}) ? dbl - {1'b0, HASH_MOD} : dbl;
        dbl_mod = dbl_red[HASH_W-1:0];
        acc     = {1'b0, dbl_mod} + (b_reg[HASH_W-1] ? {1'b0, a_reg} : '0);
        if (acc >= {1'b0, HASH_MOD})
        begin
            acc = acc - {1'b0, HASH_MOD};
        end
    end

    // Sequencing of the bit steps.
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next   = a;
            b_next   = b;
            r_next   = '0;
            cnt_next = CNT_W'(HASH_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            r_next   = acc[HASH_W-1:0];
            b_next   = {b_reg[HASH_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
    end

    assign done = done_reg;
    assign prod = r_reg;

endmodule

@@ hdl/sbrh_datapath.sv @@
// Datapath: hash and power stores, counters, base register and result register.
module sbrh_datapath #(
    parameter int unsigned MAX_LEN = sbrh_pkg::MAX_LEN_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sbrh_pkg::cmd_t              cmd,
    output sbrh_pkg::status_t           status,
    input  sbrh_pkg::item_t             item,
    input  logic                        cfg_we,
    input  logic [sbrh_pkg::HASH_W-1:0] cfg_data,
    output logic                        result_valid,
    output sbrh_pkg::result_t           result
);
    import sbrh_pkg::*;

    localparam int unsigned AW = $clog2(MAX_LEN);
    localparam int unsigned CW = $clog2(MAX_LEN + 1);

    logic [HASH_W-1:0] hash_mem [MAX_LEN];
    logic [HASH_W-1:0] pow_mem  [MAX_LEN];

    logic [HASH_W-1:0] base_reg, h_rd_reg, p_rd_reg, pow_tmp_reg, whole_reg;
    logic [7:0]        char_reg;
    logic              last_reg, ovf_reg;
    logic [CW-1:0]     len_reg, idx_reg;
    logic [LEN_OUT_W-1:0] cnt_reg;
    logic              rv_reg;
    result_t           res_reg;

    logic              rd_en;
    logic [AW-1:0]     h_addr, p_addr;
    logic [CW-1:0]     suf_idx, pre_idx, prev_idx;
    logic [HASH_W-1:0] mul_a, mul_b, mul_prod, suf, h_new;
    logic [HASH_W:0]   sum;
    logic              mul_done, match;

    // Read addresses of the two stores.
    always_comb
    begin
        suf_idx  = len_reg - idx_reg - 1'b1;
        pre_idx  = idx_reg - 1'b1;
        prev_idx = len_reg - 1'b1;
        rd_en    = 1'b1;
        h_addr   = prev_idx[AW-1:0];
        p_addr   = prev_idx[AW-1:0];
        unique case (cmd.rd_op)
            RD_PREV:
            begin
                h_addr = prev_idx[AW-1:0];
                p_addr = prev_idx[AW-1:0];
            end
            RD_WHOLE:
            begin
                h_addr = prev_idx[AW-1:0];
            end
            RD_SUFFIX:
            begin
                h_addr = suf_idx[AW-1:0];
                p_addr = idx_reg[AW-1:0];
            end
            RD_PREFIX:
            begin
                h_addr = pre_idx[AW-1:0];
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Store writes and registered reads.
    always_ff @(posedge clk)
    begin
        if (cmd.write_first)
        begin
            hash_mem[len_reg[AW-1:0]] <= {{(HASH_W-8){1'b0}}, char_reg};
            pow_mem[len_reg[AW-1:0]]  <= HASH_W'(1);
        end
        else if (cmd.write_next)
        begin
            hash_mem[len_reg[AW-1:0]] <= h_new;
            pow_mem[len_reg[AW-1:0]]  <= pow_tmp_reg;
        end
        if (rd_en)
        begin
            h_rd_reg <= hash_mem[h_addr];
            p_rd_reg <= pow_mem[p_addr];
        end
    end

    // Multiplier operands.
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_POW:
            begin
                mul_a = p_rd_reg;
                mul_b = base_reg;
            end
            MUL_HASH:
            begin
                mul_a = h_rd_reg;
                mul_b = base_reg;
            end
            default:
            begin
                mul_a = h_rd_reg;
                mul_b = p_rd_reg;
            end
        endcase
    end

    sbrh_modmul u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // New prefix hash and suffix hash reductions.
    always_comb
    begin
        sum   = {1'b0, mul_prod} + {{(HASH_W-7){1'b0}}, char_reg};
        h_new = (sum >= {1'b0, HASH_MOD}) ? HASH_W'(sum - {1'b0, HASH_MOD})
                                          : sum[HASH_W-1:0];
        suf   = (whole_reg >= mul_prod) ? whole_reg - mul_prod
                                        : whole_reg + (HASH_MOD - mul_prod);
        match = (h_rd_reg == suf);
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            char_reg <= item.char_code;
            last_reg <= item.last_char;
        end
        if (cmd.save_pow)
        begin
            pow_tmp_reg <= mul_prod;
        end
        if (cmd.latch_whole)
        begin
            whole_reg <= h_rd_reg;
        end
    end

    // Control state: base, lengths, counters and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
            len_reg  <= '0;
            idx_reg  <= '0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            rv_reg   <= 1'b0;
            res_reg  <= '0;
        end
        else
        begin
            rv_reg <= 1'b0;
            if (cfg_we)
            begin
                base_reg <= cfg_data;
            end
            if (cmd.write_first || cmd.write_next)
            begin
                len_reg <= len_reg + 1'b1;
            end
            if (cmd.mark_ovf)
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.init_search)
            begin
                idx_reg <= CW'(1);
                cnt_reg <= '0;
            end
            if (cmd.next_len)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.emit_cmp && match)
            begin
                rv_reg                <= 1'b1;
                res_reg.border_length <= idx_reg[LEN_OUT_W-1:0];
                res_reg.end_of_list   <= 1'b0;
                res_reg.truncated     <= 1'b0;
                cnt_reg               <= cnt_reg + 1'b1;
            end
            if (cmd.emit_end)
            begin
                rv_reg                <= 1'b1;
                res_reg.border_length <= '0;
                res_reg.end_of_list   <= 1'b1;
                res_reg.truncated     <= ovf_reg;
                len_reg               <= '0;
                ovf_reg               <= 1'b0;
            end
        end
    end

    // Status back to the controller.
    always_comb
    begin
        status.full        = (len_reg == CW'(MAX_LEN));
        status.empty       = (len_reg == '0);
        status.last        = last_reg;
        status.mul_done    = mul_done;
        status.search_over = (idx_reg >= len_reg) || (cnt_reg == MAX_REPORTS);
    end

    assign result_valid = rv_reg;
    assign result       = res_reg;

endmodule

@@ hdl/sbrh_ctrl.sv @@
// Controller state machine that sequences loading and the border search.
module sbrh_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  sbrh_pkg::status_t   status,
    output sbrh_pkg::cmd_t      cmd
);
    import sbrh_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (start) state_next = ST_DISP;
            ST_DISP:
            begin
                if (status.full || status.empty)
                begin
                    state_next = status.last ? ST_SINIT : ST_IDLE;
                end
                else
                begin
                    state_next = ST_MPS;
                end
            end
            ST_MPS:   state_next = ST_MPW;
            ST_MPW:   if (status.mul_done) state_next = ST_MHS;
            ST_MHS:   state_next = ST_MHW;
            ST_MHW:
            begin
                if (status.mul_done)
                begin
                    state_next = status.last ? ST_SINIT : ST_IDLE;
                end
            end
            ST_SINIT: state_next = ST_RDW;
            ST_RDW:   state_next = ST_LATW;
            ST_LATW:  state_next = status.search_over ? ST_END : ST_RDS;
            ST_RDS:   state_next = ST_MST;
            ST_MST:   state_next = ST_MWT;
            ST_MWT:   if (status.mul_done) state_next = ST_RDP;
            ST_RDP:   state_next = ST_CMP;
            ST_CMP:   state_next = ST_CHK;
            ST_CHK:   state_next = status.search_over ? ST_END : ST_RDS;
            ST_END:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd         = '0;
        cmd.rd_op   = RD_NONE;
        cmd.mul_sel = MUL_POW;
        busy        = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:  cmd.load_item = start;
            ST_DISP:
            begin
                if (status.full)
                begin
                    cmd.mark_ovf = 1'b1;
                end
                else if (status.empty)
                begin
                    cmd.write_first = 1'b1;
                end
                else
                begin
                    cmd.rd_op = RD_PREV;
                end
            end
            ST_MPS:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_POW;
            end
            ST_MPW:   cmd.save_pow = status.mul_done;
            ST_MHS:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_HASH;
            end
            ST_MHW:   cmd.write_next = status.mul_done;
            ST_SINIT: cmd.init_search = 1'b1;
            ST_RDW:   cmd.rd_op = RD_WHOLE;
            ST_LATW:  cmd.latch_whole = 1'b1;
            ST_RDS:   cmd.rd_op = RD_SUFFIX;
            ST_MST:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_SRCH;
            end
            ST_MWT:   cmd.mul_sel = MUL_SRCH;
            ST_RDP:   cmd.rd_op = RD_PREFIX;
            ST_CMP:
            begin
                cmd.emit_cmp = 1'b1;
                cmd.next_len = 1'b1;
            end
            ST_CHK:   cmd.rd_op = RD_NONE;
            ST_END:   cmd.emit_end = 1'b1;
            default:  cmd.rd_op = RD_NONE;
        endcase
    end

endmodule

@@ hdl/string_border_finder_rolling_hash_top.sv @@
// Top level of the rolling-hash border finder.
//
//  channel   ports                          handshake
//  input     start, busy, item              taken when start && !busy
//  result    result_valid, result           one-cycle strobe, no back-pressure
//  config    cfg_we, cfg_data               written when cfg_we
//
// Each stored byte after the first runs from one accept to the next through two
// modular products in the shared bit-serial multiplier, each with its launch, plus
// the dispatch state and the idle state that takes the item; the first byte and a
// dropped byte need only those two states. The search on the last byte runs its setup
// states, then a product in the same multiplier per tested length, then the end item.
// Reset is asynchronous and clears all control state; the stores need none.
// Results cannot be stalled; busy holds off new items until the end item.
module string_border_finder_rolling_hash_top #(
    parameter int unsigned MAX_LEN = sbrh_pkg::MAX_LEN_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  sbrh_pkg::item_t             item,
    output logic                        result_valid,
    output sbrh_pkg::result_t           result,
    input  logic                        cfg_we,
    input  logic [sbrh_pkg::HASH_W-1:0] cfg_data
);
    import sbrh_pkg::*;

    cmd_t    cmd;
    status_t status;

    sbrh_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    sbrh_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

@@ hdl/sbrh_checker.sv @@
// Port-level checker for the border finder and its bind to the top level.
module sbrh_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              busy,
    input logic              result_valid,
    input sbrh_pkg::result_t result
);
    import sbrh_pkg::*;

    // Border reports come while the search is still running.
    a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.end_of_list |-> busy)
        else $error("border report seen while idle");

    // The end item leaves the block ready for the next string.
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.end_of_list |-> !busy)
        else $error("block still busy on end item");

    // A border report carries a real length and no truncation flag.
    a_report_len: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.end_of_list |->
            result.border_length != '0 && !result.truncated)
        else $error("bad border report");

    // The end item carries length zero.
    a_end_len: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.end_of_list |-> result.border_length == '0)
        else $error("end item with nonzero length");

endmodule

bind string_border_finder_rolling_hash_top sbrh_checker u_sbrh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
